/* sv/pod_pkg.sv */
// ----------------------------------------------------------------------------
// pod_pkg: shared types and constants of the parking occupancy detector
// Payload structs, event codes, register indexes and the fixed-point
// constant used for the echo-to-centimetre conversion.
// ----------------------------------------------------------------------------
`default_nettype none

package pod_pkg;

    localparam int EchoW   = 20;
    localparam int TimeW   = 32;
    localparam int DistW   = 15;
    localparam int SpaceW  = 10;
    localparam int CountW  = 8;
    localparam int CycleW  = 16;
    localparam int CarW    = 16;
    localparam int EventW  = 3;
    localparam int CfgIdxW = 2;
    localparam int CfgDatW = 16;

    // floor(echo * 17150 / 1000000) == (echo * RecipMul) >> RecipShift
    // for every 20-bit echo: 2^35 exceeds 20000 * 2^20, so the rounding
    // error of the reciprocal never crosses an integer boundary.
    localparam int RecipShift = 35;
    localparam int RecipW     = 30;
    localparam logic [RecipW-1:0] RecipMul = 30'd589269514;
    localparam int ProdW      = EchoW + RecipW;

    localparam logic [DistW-1:0] RangeLowCm  = 15'd2;
    localparam logic [DistW-1:0] RangeHighCm = 15'd450;

    localparam logic [SpaceW-1:0] SpaceReset = 10'd16;
    localparam logic [CountW-1:0] MinReset   = 8'd5;
    localparam logic [CycleW-1:0] CycleReset = 16'd1500;

    localparam logic [EventW-1:0] EV_EMPTY      = 3'd0;
    localparam logic [EventW-1:0] EV_QUALIFY    = 3'd1;
    localparam logic [EventW-1:0] EV_PARKED_NOW = 3'd2;
    localparam logic [EventW-1:0] EV_STILL      = 3'd3;
    localparam logic [EventW-1:0] EV_LEFT       = 3'd4;

    localparam logic [CfgIdxW-1:0] REG_SPACE = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_MIN   = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_CYCLE = 2'd2;

    typedef struct packed {
        logic [EchoW-1:0] echo_us;
        logic [TimeW-1:0] now_ms;
    } pod_in_t;

    typedef struct packed {
        logic [DistW-1:0]  distance_cm;
        logic              in_range;
        logic              occupied;
        logic              parked;
        logic [EventW-1:0] event_code;
        logic [CarW-1:0]   car_total;
        logic [TimeW-1:0]  parked_time_ms;
    } pod_out_t;

endpackage

`default_nettype wire

/* sv/parking_occupancy_detector_unit.sv */
// ----------------------------------------------------------------------------
// parking_occupancy_detector_unit: ultrasonic parking spot occupancy detector
// Converts echo widths to distance and tracks a parked-car state machine.
// ----------------------------------------------------------------------------
`default_nettype none

// Each transfer on the s_ channel carries one echo width in microseconds and
// the current millisecond time; exactly one result transfer on the m_ channel
// follows it, in order. A reading goes through three register stages (input,
// reciprocal product, result) before its result is presented on the m_
// channel, and while m_ready stays high a new reading is taken every cycle. The
// single 20x30 constant multiply that replaces the divide by one million sets
// the second stage; the parked state machine and the parked-time sum set the
// last. Stalls on m_ready hold the pipeline stage by stage, filling bubbles
// first. Configuration writes on the cfg_ channel are always taken; index 3
// is ignored. Change configuration only while no reading is in flight.

module parking_occupancy_detector_unit
    import pod_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,

    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire pod_in_t            s_data,

    output logic                    m_valid,
    input  wire logic               m_ready,
    output pod_out_t                m_data,

    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [CfgIdxW-1:0] cfg_index,
    input  wire logic [CfgDatW-1:0] cfg_data
);

    // configuration
    logic [SpaceW-1:0]        space_reg;
    logic [CountW-1:0]        min_reg;
    logic [CycleW-1:0]        cycle_reg;
    logic [CountW+CycleW-1:0] detect_time_reg;   // min count times cycle length

    // pipeline
    logic              v0_reg, v1_reg, vo_reg;
    pod_in_t           in_reg;
    logic [ProdW-1:0]  prod_reg;
    logic [TimeW-1:0]  now1_reg;
    pod_out_t          out_reg;
    logic              en0, en1, en2;

    // detector state
    logic [CountW-1:0] qual_reg,   qual_next;
    logic              parked_reg, parked_next;
    logic [CarW-1:0]   cars_reg,   cars_next;
    logic [TimeW-1:0]  stamp_reg,  stamp_next;
    pod_out_t          out_next;

    // stage-2 combinational terms
    logic [DistW-1:0]  dist_cm;
    logic              occ;
    logic [CountW-1:0] qual_inc;

    // a stage advances when the one after it is empty or advancing
    assign en2     = !vo_reg || m_ready;
    assign en1     = !v1_reg || en2;
    assign en0     = !v0_reg || en1;
    assign s_ready = en0;

    assign cfg_ready = 1'b1;
    assign m_valid   = vo_reg;
    assign m_data    = out_reg;

    // configuration writes; unknown index drops the write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            space_reg       <= SpaceReset;
            min_reg         <= MinReset;
            cycle_reg       <= CycleReset;
            detect_time_reg <= CountW'(MinReset) * CycleReset;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    REG_SPACE: space_reg <= cfg_data[SpaceW-1:0];
                    REG_MIN:   min_reg   <= cfg_data[CountW-1:0];
                    REG_CYCLE: cycle_reg <= cfg_data[CycleW-1:0];
                    default:   ;
                endcase
            end
            // refresh every cycle from the registered minimum count and cycle length
            detect_time_reg <= min_reg * cycle_reg;
        end
    end

    // stage 0: capture the reading
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (en0) begin
            v0_reg <= s_valid;
        end
        if (en0 && s_valid) begin
            in_reg <= s_data;
        end
    end

    // stage 1: multiply by the reciprocal of the divisor
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en1) begin
            v1_reg <= v0_reg;
        end
        if (en1 && v0_reg) begin
            prod_reg <= ProdW'(in_reg.echo_us) * ProdW'(RecipMul);
            now1_reg <= in_reg.now_ms;
        end
    end

    // stage 2: classify and advance the parked state machine
    assign dist_cm  = prod_reg[RecipShift +: DistW];
    assign occ      = {1'b0, dist_cm, 1'b0} <= {7'd0, space_reg};
    assign qual_inc = (qual_reg == {CountW{1'b1}}) ? qual_reg : qual_reg + 1'b1;

    always_comb begin
        qual_next   = qual_reg;
        parked_next = parked_reg;
        cars_next   = cars_reg;
        stamp_next  = stamp_reg;

        out_next                = '0;
        out_next.distance_cm    = dist_cm;
        out_next.in_range       = (dist_cm >= RangeLowCm) && (dist_cm <= RangeHighCm);
        out_next.occupied       = occ;

        if (occ && !parked_reg) begin
            if (qual_inc >= min_reg) begin
                qual_next           = '0;
                parked_next         = 1'b1;
                cars_next           = (cars_reg == {CarW{1'b1}}) ? cars_reg
                                                                 : cars_reg + 1'b1;
                stamp_next          = now1_reg;
                out_next.event_code = EV_PARKED_NOW;
            end else begin
                qual_next           = qual_inc;
                out_next.event_code = EV_QUALIFY;
            end
        end else if (occ) begin
            out_next.event_code     = EV_STILL;
            out_next.parked_time_ms = now1_reg - stamp_reg
                                    + TimeW'(detect_time_reg);
        end else if (parked_reg) begin
            // car gone; qualify count is already zero
            parked_next         = 1'b0;
            out_next.event_code = EV_LEFT;
        end else begin
            qual_next           = '0;
            out_next.event_code = EV_EMPTY;
        end

        out_next.parked    = parked_next;
        out_next.car_total = cars_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vo_reg     <= 1'b0;
            qual_reg   <= '0;
            parked_reg <= 1'b0;
            cars_reg   <= '0;
            stamp_reg  <= '0;
        end else begin
            if (en2) begin
                vo_reg <= v1_reg;
            end
            // commit state only for a reading that moves into the result slot
            if (en2 && v1_reg) begin
                qual_reg   <= qual_next;
                parked_reg <= parked_next;
                cars_reg   <= cars_next;
                stamp_reg  <= stamp_next;
            end
        end
        if (en2 && v1_reg) begin
            out_reg <= out_next;
        end
    end

endmodule

`default_nettype wire

/* sv/pod_checker.sv */
// ----------------------------------------------------------------------------
// pod_checker: port-level checks for the parking occupancy detector
// Watches the result channel and checks consistency of reported fields.
// ----------------------------------------------------------------------------
`default_nettype none

module pod_checker
    import pod_pkg::*;
(
    input wire logic     aclk,
    input wire logic     aresetn,
    input wire logic     m_valid,
    input wire logic     m_ready,
    input wire pod_out_t m_data
);

    // a stalled result transfer holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_parked_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.parked == (m_data.event_code == EV_PARKED_NOW ||
                                      m_data.event_code == EV_STILL))
        else $error("parked flag disagrees with event code");

    a_time_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.event_code != EV_STILL |-> m_data.parked_time_ms == '0)
        else $error("parked time reported outside still-parked event");

    a_occ_event: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.occupied == (m_data.event_code == EV_QUALIFY ||
                                        m_data.event_code == EV_PARKED_NOW ||
                                        m_data.event_code == EV_STILL))
        else $error("occupied flag disagrees with event code");

    // the car total never drops from one result to the next
    a_cars_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready ##1 m_valid |-> m_data.car_total >= $past(m_data.car_total))
        else $error("car total decreased");

endmodule

bind parking_occupancy_detector_unit pod_checker u_pod_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
